### sv/fms_pkg.sv
// ----------------------------------------------------------------------------
// fms_pkg: frequency to memory slot shared definitions
// band group table, reciprocal constants and the classified word type
// ----------------------------------------------------------------------------
package fms_pkg;

  localparam int unsigned FREQ_W      = 16;
  localparam int unsigned SLOT_W      = 12;
  localparam int unsigned TABLE_SIZE  = 21;
  localparam int unsigned GROUP_COUNT = 21;
  localparam int unsigned SEARCH_N    = (GROUP_COUNT < TABLE_SIZE) ? GROUP_COUNT : TABLE_SIZE;
  localparam int unsigned GRP_W       = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned WID_W       = 15;
  localparam int unsigned OFF_W       = 15;
  localparam int unsigned NUM_W       = 22;
  localparam int unsigned RECIP_SH    = 24;
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;
  localparam int unsigned QUO_W       = 8;

  localparam logic [FREQ_W-1:0] FREQ_TOP  = 16'd55000;
  localparam logic [FREQ_W-1:0] FREQ_ONES = '1;
  localparam int unsigned       RECIP_ONE = 1 << RECIP_SH;

  localparam logic [FREQ_W-1:0] GRP_LO [TABLE_SIZE] = '{
    16'd1,     16'd1600,  16'd2200,  16'd3300,  16'd4200,  16'd6800,  16'd7500,
    16'd9810,  16'd10350, 16'd13800, 16'd14550, 16'd17868, 16'd18368, 16'd20800,
    16'd21650, 16'd24690, 16'd25190, 16'd27800, 16'd29900, 16'd49800, 16'd54200
  };

  localparam logic [FREQ_W-1:0] GRP_HI [TABLE_SIZE] = '{
    16'd1600,  16'd2200,  16'd3300,  16'd4200,  16'd6800,  16'd7500,  16'd9810,
    16'd10350, 16'd13800, 16'd14550, 16'd17868, 16'd18368, 16'd20800, 16'd21650,
    16'd24690, 16'd25190, 16'd27800, 16'd29900, 16'd49800, 16'd54200, 16'd55000
  };

  localparam logic [WID_W-1:0] GRP_WIDTH [TABLE_SIZE] = '{
    15'd1599,  15'd600,   15'd1100,  15'd900,   15'd2600,  15'd700,   15'd2310,
    15'd540,   15'd3450,  15'd750,   15'd3318,  15'd500,   15'd2432,  15'd850,
    15'd3040,  15'd500,   15'd2610,  15'd2100,  15'd19900, 15'd4400,  15'd800
  };

  localparam logic [CNT_W-1:0] GRP_CNT [TABLE_SIZE] = '{
    8'd200, 8'd100, 8'd200, 8'd200, 8'd200, 8'd100, 8'd200,
    8'd100, 8'd200, 8'd100, 8'd200, 8'd100, 8'd200, 8'd200,
    8'd200, 8'd100, 8'd200, 8'd200, 8'd200, 8'd200, 8'd100
  };

  localparam logic [SLOT_W-1:0] GRP_BASE [TABLE_SIZE] = '{
    12'd0,    12'd200,  12'd300,  12'd500,  12'd700,  12'd900,  12'd1000,
    12'd1200, 12'd1300, 12'd1500, 12'd1600, 12'd1800, 12'd1900, 12'd2100,
    12'd2300, 12'd2500, 12'd2600, 12'd2800, 12'd3000, 12'd3200, 12'd3400
  };

  // floor(2^24 / width)
  localparam logic [RECIP_W-1:0] GRP_RECIP [TABLE_SIZE] = '{
    RECIP_W'(RECIP_ONE / 1599),  RECIP_W'(RECIP_ONE / 600),   RECIP_W'(RECIP_ONE / 1100),
    RECIP_W'(RECIP_ONE / 900),   RECIP_W'(RECIP_ONE / 2600),  RECIP_W'(RECIP_ONE / 700),
    RECIP_W'(RECIP_ONE / 2310),  RECIP_W'(RECIP_ONE / 540),   RECIP_W'(RECIP_ONE / 3450),
    RECIP_W'(RECIP_ONE / 750),   RECIP_W'(RECIP_ONE / 3318),  RECIP_W'(RECIP_ONE / 500),
    RECIP_W'(RECIP_ONE / 2432),  RECIP_W'(RECIP_ONE / 850),   RECIP_W'(RECIP_ONE / 3040),
    RECIP_W'(RECIP_ONE / 500),   RECIP_W'(RECIP_ONE / 2610),  RECIP_W'(RECIP_ONE / 2100),
    RECIP_W'(RECIP_ONE / 19900), RECIP_W'(RECIP_ONE / 4400),  RECIP_W'(RECIP_ONE / 800)
  };

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [GRP_W-1:0]  grp;
    logic              ok;
  } fms_cls_t;

endpackage

### sv/fms_if.sv
// ----------------------------------------------------------------------------
// fms_if: frequency and slot channels
// valid/ready channels carrying the frequency word and the slot word
// ----------------------------------------------------------------------------
interface fms_freq_if;
  import fms_pkg::*;

  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] frequency_khz;

  modport source (output valid, output frequency_khz, input ready);
  modport sink   (input valid, input frequency_khz, output ready);
endinterface

interface fms_slot_if;
  import fms_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_index;
  logic              slot_valid;

  modport source (output valid, output slot_index, output slot_valid, input ready);
  modport sink   (input valid, input slot_index, input slot_valid, output ready);
endinterface

### sv/fms_front.sv
// ----------------------------------------------------------------------------
// fms_front: frequency classifier
// accepts frequency words and finds the band group that holds each one
// ----------------------------------------------------------------------------
module fms_front (
  fms_freq_if.sink           freq_i,
  output logic               push_valid_o,
  output fms_pkg::fms_cls_t  push_data_o,
  input  logic               push_ready_i
);
  import fms_pkg::*;

  logic [FREQ_W-1:0] f;
  logic              hit;
  logic [GRP_W-1:0]  grp;
  logic              in_range;

  assign f = freq_i.frequency_khz;

  // first group whose upper edge lies above the frequency
  always_comb begin
    hit = 1'b0;
    grp = '0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (i < SEARCH_N && GRP_HI[i] > f) begin
        hit = 1'b1;
        grp = GRP_W'(i);
      end
    end
  end

  assign in_range = (f != '0) && (f != FREQ_ONES) && (f < FREQ_TOP);

  assign push_valid_o     = freq_i.valid;
  assign push_data_o.freq = f;
  assign push_data_o.grp  = grp;
  assign push_data_o.ok   = in_range && hit;
  assign freq_i.ready     = push_ready_i;

endmodule

### sv/fms_queue.sv
// ----------------------------------------------------------------------------
// fms_queue: two-entry word queue
// decouples the classifier from the slot arithmetic
// ----------------------------------------------------------------------------
module fms_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  fms_pkg::fms_cls_t  push_data_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output fms_pkg::fms_cls_t  pop_data_o,
  input  logic               pop_ready_i
);
  import fms_pkg::*;

  fms_cls_t    entry_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;
  logic        push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/fms_back.sv
// ----------------------------------------------------------------------------
// fms_back: slot arithmetic pipeline
// scales the offset into the group, divides by the group width through a
// reciprocal with one correction step, and adds the group base
// ----------------------------------------------------------------------------
module fms_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  input  fms_pkg::fms_cls_t  pop_data_i,
  output logic               pop_ready_o,
  fms_slot_if.source         slot_o
);
  import fms_pkg::*;

  typedef struct packed {
    logic [GRP_W-1:0] grp;
    logic             ok;
    logic [NUM_W-1:0] num;
  } stage1_t;

  typedef struct packed {
    logic [GRP_W-1:0] grp;
    logic             ok;
    logic [NUM_W-1:0] num;
    logic [QUO_W-1:0] quo;
  } stage2_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              ok;
  } stage3_t;

  logic    v1_q, v2_q, v3_q;
  logic    en1, en2, en3;
  stage1_t s1_q, s1_d;
  stage2_t s2_q, s2_d;
  stage3_t s3_q, s3_d;

  logic [OFF_W-1:0]        off;
  logic [PROD_W-1:0]       prod;
  logic [NUM_W-1:0]        back_mul;
  logic [NUM_W-1:0]        rem;
  logic [QUO_W-1:0]        quo_fix;

  assign en3 = !v3_q || slot_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign pop_ready_o = en1;

  // offset times slot count
  always_comb begin
    off      = OFF_W'(pop_data_i.freq - GRP_LO[pop_data_i.grp]);
    s1_d.grp = pop_data_i.grp;
    s1_d.ok  = pop_data_i.ok;
    s1_d.num = NUM_W'(off * GRP_CNT[pop_data_i.grp]);
  end

  // quotient estimate, low by at most one
  always_comb begin
    prod     = PROD_W'(s1_q.num * GRP_RECIP[s1_q.grp]);
    s2_d.grp = s1_q.grp;
    s2_d.ok  = s1_q.ok;
    s2_d.num = s1_q.num;
    s2_d.quo = prod[RECIP_SH +: QUO_W];
  end

  // correction and base add
  always_comb begin
    back_mul = NUM_W'(s2_q.quo * GRP_WIDTH[s2_q.grp]);
    rem      = s2_q.num - back_mul;
    quo_fix  = s2_q.quo + QUO_W'(rem >= NUM_W'(GRP_WIDTH[s2_q.grp]));
    s3_d.ok  = s2_q.ok;
    s3_d.slot = s2_q.ok ? (GRP_BASE[s2_q.grp] + SLOT_W'(quo_fix)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pop_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
  end

  assign slot_o.valid      = v3_q;
  assign slot_o.slot_index = s3_q.slot;
  assign slot_o.slot_valid = s3_q.ok;

endmodule

### sv/frequency_to_memory_slot_top.sv
// ----------------------------------------------------------------------------
// frequency_to_memory_slot_top: frequency to memory slot mapper
// Maps a frequency in kHz to a memory slot index from a table of 21 band
// groups. One word is accepted every cycle while the slot side is ready. An
// accepted word is held in the queue, then passes the offset scaling, the
// reciprocal multiply and the correction and base add stages, one register
// each, before its result is offered. With the slot side stalled the block
// holds five words, two in the queue and three in the pipeline, before it
// stalls its input. Frequencies of zero, all ones or at least 55000 kHz
// return slot 0 with slot_valid low.
// ----------------------------------------------------------------------------
module frequency_to_memory_slot_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  fms_freq_if.sink    freq_i,
  fms_slot_if.source  slot_o
);
  import fms_pkg::*;

  logic     push_valid, push_ready;
  fms_cls_t push_data;
  logic     pop_valid, pop_ready;
  fms_cls_t pop_data;

  fms_front u_front (
    .freq_i       (freq_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  fms_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  fms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .slot_o      (slot_o)
  );

endmodule
